### rtl/triangle_barycentric_coordinates_defines.svh
// Assertion macros used by the checker file of the barycentric weight block.
// Depends on nothing; included by files that write concurrent assertions.
`ifndef TRIANGLE_BARYCENTRIC_COORDINATES_DEFINES_SVH
`define TRIANGLE_BARYCENTRIC_COORDINATES_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TBC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("barycentric block assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("barycentric block assertion failed");

`endif

### rtl/tbc_pkg.sv
// Types, widths and helper functions of the barycentric weight block.
// Depends on nothing; used by the interfaces, the divider, the top level and the checker.
package tbc_pkg;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int MAG_W      = SUM_W - 1;
    localparam int FRAC_SHIFT = 25;
    localparam int NUM_W      = MAG_W + FRAC_SHIFT;
    localparam int DEN_W      = MAG_W + 1;
    localparam int QRES_W     = NUM_W + 1;
    localparam int WSUM_W     = QRES_W + 1;
    localparam int WEIGHT_W   = 32;
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic signed [DIFF_W-1:0]   diff_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic        [MAG_W-1:0]    mag_t;
    typedef logic        [NUM_W-1:0]    num_t;
    typedef logic        [DEN_W-1:0]    den_t;
    typedef logic signed [QRES_W-1:0]   qres_t;
    typedef logic signed [WSUM_W-1:0]   wsum_t;
    typedef logic signed [WEIGHT_W-1:0] weight_t;

    localparam weight_t ONE_Q24    = 32'sh0100_0000;
    localparam weight_t WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
    localparam weight_t WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CORNER_A_X = 3'd0,
        REG_CORNER_A_Y = 3'd1,
        REG_CORNER_B_X = 3'd2,
        REG_CORNER_B_Y = 3'd3,
        REG_CORNER_C_X = 3'd4,
        REG_CORNER_C_Y = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        weight_t value;
        logic    sat;
    } clamp_t;

    // Clamps a wide signed weight to the Q8.24 range and reports whether it was clipped.
    function automatic clamp_t clamp_weight(wsum_t v);
        clamp_t r;
        logic [WSUM_W-WEIGHT_W:0] upper;
        upper = v[WSUM_W-1:WEIGHT_W-1];
        if (upper == '0 || upper == '1)
        begin
            r.value = v[WEIGHT_W-1:0];
            r.sat   = 1'b0;
        end
        else if (v[WSUM_W-1])
        begin
            r.value = WEIGHT_MIN;
            r.sat   = 1'b1;
        end
        else
        begin
            r.value = WEIGHT_MAX;
            r.sat   = 1'b1;
        end
        return r;
    endfunction

endpackage

### rtl/tbc_if.sv
// Valid/ready stream interfaces for query points and weight results.
// Depends on tbc_pkg for the field types.
interface tbc_query_if;
    import tbc_pkg::*;

    logic   valid;
    logic   ready;
    coord_t point_u;
    coord_t point_v;

    modport source (output valid, output point_u, output point_v, input ready);
    modport sink (input valid, input point_u, input point_v, output ready);
endinterface

interface tbc_result_if;
    import tbc_pkg::*;

    logic    valid;
    logic    ready;
    weight_t weight_a;
    weight_t weight_b;
    weight_t weight_c;
    logic    empty_flag;
    logic    saturated;

    modport source (output valid, output weight_a, output weight_b, output weight_c,
                    output empty_flag, output saturated, input ready);
    modport sink (input valid, input weight_a, input weight_b, input weight_c,
                  input empty_flag, input saturated, output ready);
endinterface

### rtl/triangle_barycentric_coordinates.sv
// Barycentric weights of a stream of query points against a triangle held in six corner
// registers (signed Q16.16). The block takes one query beat per clock unless a stalled result
// holds the pipeline, and returns one result beat per query, in order; the depth is set by the two
// 91-stage restoring dividers that work out the rounded Q8.24 weights one quotient bit per
// stage. A result waiting at the output does not block new queries while the stage ahead of
// the output register is empty. Corners may be written only while no beat is in flight; a
// query may follow in the cycle after the last write. Weights round to nearest, ties away
// from zero, and clamp with the saturated flag; a zero determinant gives all-zero weights.
// Depends on tbc_pkg, tbc_if and tbc_divider.
module triangle_barycentric_coordinates (
    input  logic                           clk,
    input  logic                           rst_n,
    tbc_query_if.sink                      query,
    tbc_result_if.source                   result,
    input  logic                           cfg_we,
    input  logic [tbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tbc_pkg::COORD_W-1:0]    cfg_data
);
    import tbc_pkg::*;

    localparam int STAGES = NUM_W + 7;
    localparam int LAST   = STAGES - 1;

    coord_t corner_a_x_reg, corner_a_y_reg;
    coord_t corner_b_x_reg, corner_b_y_reg;
    coord_t corner_c_x_reg, corner_c_y_reg;

    // Values derived from the corners, refreshed every cycle one step ahead of the queries.
    diff_t      dy_bc_reg, dx_cb_reg, dy_ca_reg, dx_ac_reg;
    diff_t      dx_ba_reg, dy_ba_reg, dx_ca_reg, dy_ac_reg;
    logic [1:0] same_c1_reg, same_c2_reg, same_c3_reg;
    prod_t      dp1_reg, dp2_reg, xp1_reg, xp2_reg;
    sum_t       det_reg, cross_reg;
    mag_t       dmag_reg;
    logic       dzero_reg;
    logic       empty_reg;

    logic [STAGES-1:0] valid_reg;
    logic              advance;
    logic              load_out;

    diff_t  du_reg, dv_reg;
    prod_t  pa1_reg, pa2_reg, pb1_reg, pb2_reg;
    sum_t   na_reg, nb_reg;
    mag_t   mag_a_reg, mag_b_reg;
    logic   neg_a_reg, neg_b_reg;
    num_t   num_a_reg, num_b_reg;
    logic   sgn_a_reg, sgn_b_reg;
    num_t   quo_a, quo_b;
    logic   qneg_a, qneg_b;
    qres_t  qa_ext, qb_ext;
    qres_t  ra_reg, rb_reg;
    clamp_t ca_reg, cb_reg;
    wsum_t  rc_reg;
    clamp_t cc;
    den_t   den;

    logic    out_valid_reg;
    weight_t weight_a_reg, weight_b_reg, weight_c_reg;
    logic    empty_flag_reg, saturated_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_a_x_reg <= '0;
            corner_a_y_reg <= '0;
            corner_b_x_reg <= '0;
            corner_b_y_reg <= '0;
            corner_c_x_reg <= '0;
            corner_c_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CORNER_A_X: corner_a_x_reg <= cfg_data;
                REG_CORNER_A_Y: corner_a_y_reg <= cfg_data;
                REG_CORNER_B_X: corner_b_x_reg <= cfg_data;
                REG_CORNER_B_Y: corner_b_y_reg <= cfg_data;
                REG_CORNER_C_X: corner_c_x_reg <= cfg_data;
                REG_CORNER_C_Y: corner_c_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        dy_bc_reg   <= DIFF_W'(corner_b_y_reg) - DIFF_W'(corner_c_y_reg);
        dx_cb_reg   <= DIFF_W'(corner_c_x_reg) - DIFF_W'(corner_b_x_reg);
        dy_ca_reg   <= DIFF_W'(corner_c_y_reg) - DIFF_W'(corner_a_y_reg);
        dx_ac_reg   <= DIFF_W'(corner_a_x_reg) - DIFF_W'(corner_c_x_reg);
        dx_ba_reg   <= DIFF_W'(corner_b_x_reg) - DIFF_W'(corner_a_x_reg);
        dy_ba_reg   <= DIFF_W'(corner_b_y_reg) - DIFF_W'(corner_a_y_reg);
        dx_ca_reg   <= DIFF_W'(corner_c_x_reg) - DIFF_W'(corner_a_x_reg);
        dy_ac_reg   <= DIFF_W'(corner_a_y_reg) - DIFF_W'(corner_c_y_reg);
        same_c1_reg <= {(corner_b_x_reg == corner_c_x_reg) && (corner_b_y_reg == corner_c_y_reg),
                        (corner_a_x_reg == corner_b_x_reg) && (corner_a_y_reg == corner_b_y_reg)};

        dp1_reg     <= dy_bc_reg * dx_ac_reg;
        dp2_reg     <= dx_cb_reg * dy_ac_reg;
        xp1_reg     <= dx_ba_reg * dy_ca_reg;
        xp2_reg     <= dx_ca_reg * dy_ba_reg;
        same_c2_reg <= same_c1_reg;

        det_reg     <= SUM_W'(dp1_reg) + SUM_W'(dp2_reg);
        cross_reg   <= SUM_W'(xp1_reg) - SUM_W'(xp2_reg);
        same_c3_reg <= same_c2_reg;

        dmag_reg    <= MAG_W'(det_reg[SUM_W-1] ? -det_reg : det_reg);
        dzero_reg   <= (det_reg == '0);
        empty_reg   <= same_c3_reg[0] || same_c3_reg[1] || cross_reg[SUM_W-1] ||
                       (cross_reg == '0);
    end

    assign advance     = !valid_reg[LAST] || !out_valid_reg || result.ready;
    assign load_out    = !out_valid_reg || result.ready;
    assign query.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], query.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            du_reg    <= DIFF_W'(query.point_u) - DIFF_W'(corner_c_x_reg);
            dv_reg    <= DIFF_W'(query.point_v) - DIFF_W'(corner_c_y_reg);

            pa1_reg   <= dy_bc_reg * du_reg;
            pa2_reg   <= dx_cb_reg * dv_reg;
            pb1_reg   <= dy_ca_reg * du_reg;
            pb2_reg   <= dx_ac_reg * dv_reg;

            na_reg    <= SUM_W'(pa1_reg) + SUM_W'(pa2_reg);
            nb_reg    <= SUM_W'(pb1_reg) + SUM_W'(pb2_reg);

            mag_a_reg <= MAG_W'(na_reg[SUM_W-1] ? -na_reg : na_reg);
            mag_b_reg <= MAG_W'(nb_reg[SUM_W-1] ? -nb_reg : nb_reg);
            neg_a_reg <= na_reg[SUM_W-1] ^ det_reg[SUM_W-1];
            neg_b_reg <= nb_reg[SUM_W-1] ^ det_reg[SUM_W-1];

            num_a_reg <= {mag_a_reg, {FRAC_SHIFT{1'b0}}} + NUM_W'(dmag_reg);
            num_b_reg <= {mag_b_reg, {FRAC_SHIFT{1'b0}}} + NUM_W'(dmag_reg);
            sgn_a_reg <= neg_a_reg;
            sgn_b_reg <= neg_b_reg;

            ra_reg    <= qneg_a ? -qa_ext : qa_ext;
            rb_reg    <= qneg_b ? -qb_ext : qb_ext;

            ca_reg    <= clamp_weight(wsum_t'(ra_reg));
            cb_reg    <= clamp_weight(wsum_t'(rb_reg));
            rc_reg    <= wsum_t'(ONE_Q24) - wsum_t'(ra_reg) - wsum_t'(rb_reg);
        end
    end

    // The rounded quotient is floor((|n| * 2^25 + |d|) / (2 |d|)).
    assign den = {dmag_reg, 1'b0};

    tbc_divider u_div_a (
        .clk     (clk),
        .en      (advance),
        .num     (num_a_reg),
        .den     (den),
        .neg     (sgn_a_reg),
        .quo     (quo_a),
        .quo_neg (qneg_a)
    );

    tbc_divider u_div_b (
        .clk     (clk),
        .en      (advance),
        .num     (num_b_reg),
        .den     (den),
        .neg     (sgn_b_reg),
        .quo     (quo_b),
        .quo_neg (qneg_b)
    );

    assign qa_ext = {1'b0, quo_a};
    assign qb_ext = {1'b0, quo_b};
    assign cc     = clamp_weight(rc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= valid_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            weight_a_reg   <= dzero_reg ? '0 : ca_reg.value;
            weight_b_reg   <= dzero_reg ? '0 : cb_reg.value;
            weight_c_reg   <= dzero_reg ? '0 : cc.value;
            saturated_reg  <= !dzero_reg && (ca_reg.sat || cb_reg.sat || cc.sat);
            empty_flag_reg <= empty_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.weight_a   = weight_a_reg;
    assign result.weight_b   = weight_b_reg;
    assign result.weight_c   = weight_c_reg;
    assign result.empty_flag = empty_flag_reg;
    assign result.saturated  = saturated_reg;

endmodule

### rtl/tbc_divider.sv
// Fully pipelined restoring divider, one quotient bit per stage, with a sign bit riding along.
// Depends on tbc_pkg for widths.
module tbc_divider (
    input  logic          clk,
    input  logic          en,
    input  tbc_pkg::num_t num,
    input  tbc_pkg::den_t den,
    input  logic          neg,
    output tbc_pkg::num_t quo,
    output logic          quo_neg
);
    import tbc_pkg::*;

    den_t             rem_reg [NUM_W];
    num_t             nq_reg  [NUM_W];
    logic [NUM_W-1:0] neg_reg;

    den_t rem_src  [NUM_W];
    num_t nq_src   [NUM_W];
    den_t rem_next [NUM_W];
    num_t nq_next  [NUM_W];

    always_comb
    begin
        rem_src[0] = '0;
        nq_src[0]  = num;
        for (int i = 1; i < NUM_W; i++)
        begin
            rem_src[i] = rem_reg[i-1];
            nq_src[i]  = nq_reg[i-1];
        end
    end

    always_comb
    begin
        logic [DEN_W:0] shifted;
        logic [DEN_W:0] trial;
        logic           take;
        for (int i = 0; i < NUM_W; i++)
        begin
            shifted     = {rem_src[i], nq_src[i][NUM_W-1]};
            trial       = shifted - {1'b0, den};
            take        = (shifted >= {1'b0, den});
            rem_next[i] = take ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
            nq_next[i]  = {nq_src[i][NUM_W-2:0], take};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_W; i++)
            begin
                rem_reg[i] <= rem_next[i];
                nq_reg[i]  <= nq_next[i];
            end
            neg_reg <= {neg_reg[NUM_W-2:0], neg};
        end
    end

    assign quo     = nq_reg[NUM_W-1];
    assign quo_neg = neg_reg[NUM_W-1];

endmodule

### rtl/tbc_checker.sv
// Port-level checker for the barycentric weight block, bound to the top level.
// Depends on tbc_pkg and triangle_barycentric_coordinates_defines.svh.
`include "triangle_barycentric_coordinates_defines.svh"

module tbc_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             result_valid,
    input logic             result_ready,
    input tbc_pkg::weight_t weight_a,
    input tbc_pkg::weight_t weight_b,
    input tbc_pkg::weight_t weight_c,
    input logic             empty_flag,
    input logic             saturated
);
    import tbc_pkg::*;

    // A stalled result beat keeps its contents.
    `TBC_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(weight_a) && $stable(weight_b) && $stable(weight_c) && $stable(empty_flag) && $stable(saturated))

    // Without clipping, and unless all three are zero, the three weights add up to one.
    `TBC_ASSERT_IMPLY(a_weight_sum, clk, rst_n, result_valid && !saturated && !(weight_a == 0 && weight_b == 0 && weight_c == 0), weight_c == ONE_Q24 - weight_a - weight_b)

    // A clipped result shows at least one weight at a range bound.
    `TBC_ASSERT_IMPLY(a_sat_bound, clk, rst_n, result_valid && saturated, weight_a == WEIGHT_MAX || weight_a == WEIGHT_MIN || weight_b == WEIGHT_MAX || weight_b == WEIGHT_MIN || weight_c == WEIGHT_MAX || weight_c == WEIGHT_MIN)

    // All-zero weights only come from a flat triangle.
    `TBC_ASSERT_IMPLY(a_zero_flat, clk, rst_n, result_valid && weight_a == 0 && weight_b == 0 && weight_c == 0, empty_flag && !saturated)

endmodule

bind triangle_barycentric_coordinates tbc_checker u_tbc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .weight_a     (result.weight_a),
    .weight_b     (result.weight_b),
    .weight_c     (result.weight_c),
    .empty_flag   (result.empty_flag),
    .saturated    (result.saturated)
);

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the triangle barycentric weight block.
// Depends on tbc_pkg, the tbc_query_if and tbc_result_if interfaces, and the block itself.
module tb_top;
    import tbc_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        weight_t weight_a;
        weight_t weight_b;
        weight_t weight_c;
        logic    empty_flag;
        logic    saturated;
    } weights_t;

    localparam int PIPE_LATENCY = 98;
    localparam int STALL_LIMIT  = 5000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam coord_t Q16_ONE   = 32'sh0001_0000;
    localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
    localparam coord_t COORD_MIN = 32'sh8000_0000;
    localparam coord_t TIE_SIDE  = 32'sh0200_0000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_data;
    logic                 sink_ready = 1'b0;

    coord_t   corner_reg [6] = '{default: '0};
    weights_t pending_weights [$];
    int       send_idle_pct = 28;
    int       recv_idle_pct = 61;
    int       fail_count    = 0;
    int       stall_cycles  = 0;

    tbc_query_if  query_ch ();
    tbc_result_if result_ch ();

    assign result_ch.ready = sink_ready;

    triangle_barycentric_coordinates dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .query     (query_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic wide_t orientation(coord_t t [6]);
        wide_t xa, ya, xb, yb, xc, yc;
        xa = t[REG_CORNER_A_X];
        ya = t[REG_CORNER_A_Y];
        xb = t[REG_CORNER_B_X];
        yb = t[REG_CORNER_B_Y];
        xc = t[REG_CORNER_C_X];
        yc = t[REG_CORNER_C_Y];
        return (xb - xa) * (yc - ya) - (xc - xa) * (yb - ya);
    endfunction

    // Quotient n / d scaled to Q8.24, rounded to nearest with ties away from zero.
    function automatic wide_t round_q24(wide_t n, wide_t d);
        wide_t mag_n, mag_d, q;
        mag_n = (n < 0) ? -n : n;
        mag_d = (d < 0) ? -d : d;
        q = ((mag_n <<< FRAC_SHIFT) + mag_d) / (mag_d <<< 1);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic weight_t clamp_q824(input wide_t v, inout logic sat);
        if (v > WEIGHT_MAX)
        begin
            sat = 1'b1;
            return WEIGHT_MAX;
        end
        if (v < WEIGHT_MIN)
        begin
            sat = 1'b1;
            return WEIGHT_MIN;
        end
        return weight_t'(v);
    endfunction

    function automatic weights_t predict_weights(coord_t u, coord_t v);
        wide_t    xa, ya, xb, yb, xc, yc, pu, pv, det, ra, rb;
        weights_t w;
        logic     sat;
        xa = corner_reg[REG_CORNER_A_X];
        ya = corner_reg[REG_CORNER_A_Y];
        xb = corner_reg[REG_CORNER_B_X];
        yb = corner_reg[REG_CORNER_B_Y];
        xc = corner_reg[REG_CORNER_C_X];
        yc = corner_reg[REG_CORNER_C_Y];
        pu = u;
        pv = v;
        w = '0;
        w.empty_flag = (xa == xb && ya == yb) || (xb == xc && yb == yc) ||
                       (orientation(corner_reg) <= 0);
        det = (yb - yc) * (xa - xc) + (xc - xb) * (ya - yc);
        if (det != 0)
        begin
            ra = round_q24((yb - yc) * (pu - xc) + (xc - xb) * (pv - yc), det);
            rb = round_q24((yc - ya) * (pu - xc) + (xa - xc) * (pv - yc), det);
            sat = 1'b0;
            w.weight_a = clamp_q824(ra, sat);
            w.weight_b = clamp_q824(rb, sat);
            w.weight_c = clamp_q824(wide_t'(ONE_Q24) - ra - rb, sat);
            w.saturated = sat;
        end
        return w;
    endfunction

    function automatic coord_t rand_coord(int scale);
        coord_t r;
        r = $urandom;
        if (scale < 31)
            r = r >>> (31 - scale);
        return r;
    endfunction

    // Picks a coordinate inside the corners' span, widened by a quarter on each side.
    function automatic coord_t box_coord(coord_t a, coord_t b, coord_t c);
        longint lo, hi, span, val;
        lo = a;
        hi = a;
        if (b < lo) lo = b;
        if (c < lo) lo = c;
        if (b > hi) hi = b;
        if (c > hi) hi = c;
        span = hi - lo + 1;
        val = lo - span / 4 + ((span * 3 / 2) * longint'($urandom_range(65535))) / 65536;
        if (val > COORD_MAX) val = COORD_MAX;
        if (val < COORD_MIN) val = COORD_MIN;
        return coord_t'(val);
    endfunction

    function automatic void make_triangle(output coord_t t [6], output int scale);
        int     kind;
        coord_t dx, dy, tmp;
        scale = ($urandom_range(9) == 0) ? 31 : $urandom_range(4, 30);
        for (int i = 0; i < 6; i++)
            t[i] = rand_coord(scale);
        kind = $urandom_range(19);
        if (kind == 0)
        begin
            t[REG_CORNER_B_X] = t[REG_CORNER_A_X];
            t[REG_CORNER_B_Y] = t[REG_CORNER_A_Y];
        end
        else if (kind == 1)
        begin
            t[REG_CORNER_C_X] = t[REG_CORNER_B_X];
            t[REG_CORNER_C_Y] = t[REG_CORNER_B_Y];
        end
        else if (kind == 2)
        begin
            dx = rand_coord(12);
            dy = rand_coord(12);
            t[REG_CORNER_C_X] = t[REG_CORNER_A_X] + dx;
            t[REG_CORNER_C_Y] = t[REG_CORNER_A_Y] + dy;
            t[REG_CORNER_B_X] = t[REG_CORNER_A_X] + 2 * dx;
            t[REG_CORNER_B_Y] = t[REG_CORNER_A_Y] + 2 * dy;
        end
        // Most triangles are turned counterclockwise so that the weights are meaningful.
        if (orientation(t) < 0 && $urandom_range(3) != 0)
        begin
            tmp = t[REG_CORNER_B_X];
            t[REG_CORNER_B_X] = t[REG_CORNER_C_X];
            t[REG_CORNER_C_X] = tmp;
            tmp = t[REG_CORNER_B_Y];
            t[REG_CORNER_B_Y] = t[REG_CORNER_C_Y];
            t[REG_CORNER_C_Y] = tmp;
        end
    endfunction

    function automatic void rand_point(coord_t t [6], int scale, output coord_t u,
                                       output coord_t v);
        int mode, pick;
        mode = $urandom_range(99);
        pick = $urandom_range(2);
        if (mode < 50)
        begin
            u = box_coord(t[REG_CORNER_A_X], t[REG_CORNER_B_X], t[REG_CORNER_C_X]);
            v = box_coord(t[REG_CORNER_A_Y], t[REG_CORNER_B_Y], t[REG_CORNER_C_Y]);
        end
        else if (mode < 65)
        begin
            u = t[2 * pick];
            v = t[2 * pick + 1];
        end
        else if (mode < 85)
        begin
            u = rand_coord(scale);
            v = rand_coord(scale);
        end
        else
        begin
            u = $urandom;
            v = $urandom;
        end
    endfunction

    task automatic send_query(coord_t u, coord_t v);
        if ($urandom_range(99) < send_idle_pct)
        begin
            query_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        query_ch.valid   <= 1'b1;
        query_ch.point_u <= u;
        query_ch.point_v <= v;
        @(posedge clk);
        while (!query_ch.ready)
            @(posedge clk);
        pending_weights.push_back(predict_weights(u, v));
    endtask

    task automatic drain_results();
        query_ch.valid <= 1'b0;
        while (pending_weights.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_corner(logic [CFG_IDX_W-1:0] idx, coord_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx <= REG_CORNER_C_Y)
            corner_reg[idx] = val;
    endtask

    task automatic load_triangle(coord_t t [6], bit with_spare);
        drain_results();
        if (with_spare)
        begin
            write_corner(REG_SPARE_6, $urandom);
            write_corner(REG_SPARE_7, $urandom);
        end
        write_corner(REG_CORNER_A_X, t[REG_CORNER_A_X]);
        write_corner(REG_CORNER_A_Y, t[REG_CORNER_A_Y]);
        write_corner(REG_CORNER_B_X, t[REG_CORNER_B_X]);
        write_corner(REG_CORNER_B_Y, t[REG_CORNER_B_Y]);
        write_corner(REG_CORNER_C_X, t[REG_CORNER_C_X]);
        write_corner(REG_CORNER_C_Y, t[REG_CORNER_C_Y]);
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_query('0, '0);
        send_query(Q16_ONE, COORD_MIN);
    endtask

    task automatic test_unit_triangle();
        coord_t corners [6];
        corners = '{'0, '0, Q16_ONE, '0, '0, Q16_ONE};
        load_triangle(corners, 1'b1);
        send_query('0, '0);
        send_query(Q16_ONE, '0);
        send_query('0, Q16_ONE);
        send_query(32'sh0000_5555, 32'sh0000_5555);
        send_query(COORD_MAX, COORD_MAX);
        send_query(COORD_MIN, COORD_MIN);
        send_query(COORD_MIN, COORD_MAX);
        send_query(-Q16_ONE, 2 * Q16_ONE);
    endtask

    task automatic test_rounding_ties();
        coord_t corners [6];
        corners = '{'0, '0, TIE_SIDE, '0, '0, TIE_SIDE};
        load_triangle(corners, 1'b0);
        send_query(32'sd1, '0);
        send_query(-32'sd1, '0);
        send_query(32'sd3, 32'sd1);
        send_query('0, -32'sd3);
    endtask

    task automatic test_degenerate();
        coord_t corners [6];
        corners = '{'0, '0, '0, Q16_ONE, Q16_ONE, '0};
        load_triangle(corners, 1'b0);
        send_query(Q16_ONE / 4, Q16_ONE / 4);
        corners = '{Q16_ONE, Q16_ONE, Q16_ONE, Q16_ONE, '0, '0};
        load_triangle(corners, 1'b0);
        send_query(Q16_ONE / 2, '0);
        corners = '{'0, '0, Q16_ONE, Q16_ONE, Q16_ONE, Q16_ONE};
        load_triangle(corners, 1'b0);
        send_query('0, Q16_ONE / 2);
        corners = '{'0, '0, Q16_ONE, Q16_ONE, 2 * Q16_ONE, 2 * Q16_ONE};
        load_triangle(corners, 1'b0);
        send_query(Q16_ONE, '0);
    endtask

    task automatic test_extreme_corners();
        coord_t corners [6];
        corners = '{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX};
        load_triangle(corners, 1'b0);
        send_query(COORD_MIN, COORD_MIN);
        send_query(COORD_MAX, COORD_MAX);
        send_query('0, '0);
        send_query(COORD_MAX, COORD_MIN);
    endtask

    task automatic test_random_stream(int send_pct, int recv_pct, int triangles, int points);
        coord_t corners [6];
        coord_t u, v;
        int     scale;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < triangles; n++)
        begin
            make_triangle(corners, scale);
            load_triangle(corners, 1'b0);
            for (int p = 0; p < points; p++)
            begin
                rand_point(corners, scale, u, v);
                send_query(u, v);
                if (n == 0 && p == points / 2)
                    drain_results();
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        weights_t got;
        weights_t want;
        if (rst_n)
        begin
            if (result_ch.valid && sink_ready)
            begin
                got = {result_ch.weight_a, result_ch.weight_b, result_ch.weight_c,
                       result_ch.empty_flag, result_ch.saturated};
                if (pending_weights.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("Unexpected result beat: a=%h b=%h c=%h empty=%b sat=%b",
                                 got.weight_a, got.weight_b, got.weight_c,
                                 got.empty_flag, got.saturated);
                    fail_count++;
                end
                else
                begin
                    want = pending_weights.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("Mismatch: got a=%h b=%h c=%h empty=%b sat=%b",
                                     got.weight_a, got.weight_b, got.weight_c,
                                     got.empty_flag, got.saturated);
                            $display("  expected a=%h b=%h c=%h empty=%b sat=%b",
                                     want.weight_a, want.weight_b, want.weight_c,
                                     want.empty_flag, want.saturated);
                        end
                        fail_count++;
                    end
                end
            end
            sink_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((query_ch.valid && query_ch.ready) || (result_ch.valid && sink_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        query_ch.valid   <= 1'b0;
        query_ch.point_u <= '0;
        query_ch.point_v <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_unit_triangle();
        test_rounding_ties();
        test_degenerate();
        test_extreme_corners();
        test_random_stream(28, 61, 4, 133);
        test_random_stream(61, 28, 4, 133);
        test_random_stream(0, 0, 4, 133);
        drain_results();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
